FILE: sv/triangle_scanline_span_gen_unit_assert.svh
// Assertion macros for the triangle span generator checker
`ifndef TRIANGLE_SCANLINE_SPAN_GEN_UNIT_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_GEN_UNIT_ASSERT_SVH

// checked only outside reset
`define TSSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TSSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tssg_pkg.sv
// ---------------------------------------------------------------------------
// tssg_pkg
// Types and constants shared by the triangle span generator modules.
// ---------------------------------------------------------------------------
`default_nettype none
package tssg_pkg;

    localparam int CoordBits = 16;
    localparam int CfgBits   = 13;
    localparam int ColBits   = 12;
    localparam int GuardBits = CoordBits + 4;
    localparam logic [GuardBits-1:0] GuardInit = GuardBits'(1) << (CoordBits + 3);
    localparam logic [CfgBits-1:0]   FrameMax  = CfgBits'(4096);
    localparam logic [CfgBits-1:0]   WidthRst  = CfgBits'(640);
    localparam logic [CfgBits-1:0]   HeightRst = CfgBits'(480);
    localparam logic                 ReqLoad   = 1'b0;
    localparam logic                 CfgWidth  = 1'b0;
    localparam logic                 CfgHeight = 1'b1;

    typedef struct packed {
        logic                        req_type;
        logic signed [CoordBits-1:0] vert0_x;
        logic signed [CoordBits-1:0] vert0_y;
        logic signed [CoordBits-1:0] vert1_x;
        logic signed [CoordBits-1:0] vert1_y;
        logic signed [CoordBits-1:0] vert2_x;
        logic signed [CoordBits-1:0] vert2_y;
    } t_in_word;

    typedef struct packed {
        logic signed [CoordBits-1:0] span_row;
        logic [ColBits-1:0]          span_left;
        logic [ColBits-1:0]          span_right;
        logic                        span_visible;
        logic                        span_last;
    } t_out_word;

    typedef struct packed {
        logic latch;
        logic init;
        logic seg;
        logic sel;
        logic guard_load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic hit;
        logic guard_zero;
        logic at_end;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

FILE: sv/tssg_dp.sv
// ---------------------------------------------------------------------------
// tssg_dp
// Datapath: vertex store, two Bresenham walkers sharing one step/init unit,
// row counter, frame registers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module tssg_dp (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire                                    i_cfg_addr,
    input  wire [tssg_pkg::CfgBits-1:0]            i_cfg_data,
    input  tssg_pkg::t_in_word                     i_in_word,
    input  tssg_pkg::t_cmd                         i_cmd,
    output tssg_pkg::t_stat                        o_stat,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output tssg_pkg::t_out_word                    o_out_word
);
    localparam int CB = tssg_pkg::CoordBits;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        logic signed [CB+1:0] err;
        logic [CB:0]          dmaj;
        logic [CB:0]          dmin;
        logic                 xmaj;
        logic signed [1:0]    maj;
        logic signed [1:0]    mnr;
        logic signed [CB-1:0] ox;
        logic signed [CB:0]   oy;
    } t_walker;

    logic signed [CB-1:0]          r_vx [3];
    logic signed [CB-1:0]          r_vy [3];
    t_walker                       r_w  [2];
    logic signed [CB-1:0]          r_cur_row;
    logic signed [CB-1:0]          r_bottom;
    logic                          r_active;
    logic [tssg_pkg::GuardBits-1:0] r_guard;
    logic [tssg_pkg::CfgBits-1:0]  r_fw;
    logic [tssg_pkg::CfgBits-1:0]  r_fh;
    logic                          r_out_valid;
    tssg_pkg::t_out_word           r_out;

    function automatic logic signed [1:0] f_sgn(input logic signed [CB:0] v);
        f_sgn = (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
    endfunction

    function automatic t_walker f_init(input t_walker w,
                                       input logic signed [CB-1:0] ax,
                                       input logic signed [CB-1:0] ay,
                                       input logic signed [CB-1:0] bx,
                                       input logic signed [CB-1:0] by);
        t_walker            r;
        logic signed [CB:0] dx;
        logic signed [CB:0] dy;
        logic [CB:0]        adx;
        logic [CB:0]        ady;
        r   = w;
        dx  = {bx[CB-1], bx} - {ax[CB-1], ax};
        dy  = {by[CB-1], by} - {ay[CB-1], ay};
        adx = dx[CB] ? (CB+1)'(-dx) : dx;
        ady = dy[CB] ? (CB+1)'(-dy) : dy;
        r.ex = bx;
        r.ey = by;
        if (adx > ady) begin
            r.xmaj = 1'b1;
            r.dmaj = adx;
            r.dmin = ady;
            r.maj  = f_sgn(dx);
            r.mnr  = f_sgn(dy);
        end else begin
            r.xmaj = 1'b0;
            r.dmaj = ady;
            r.dmin = adx;
            r.maj  = f_sgn(dy);
            r.mnr  = f_sgn(dx);
        end
        r.px  = ax;
        r.py  = ay;
        r.err = -$signed({2'b00, r.dmaj[CB:1]});
        return r;
    endfunction

    // swapped vertices of an incoming load
    logic signed [CB-1:0] s_vx [3];
    logic signed [CB-1:0] s_vy [3];
    always_comb begin
        s_vx[0] = i_in_word.vert0_x; s_vy[0] = i_in_word.vert0_y;
        s_vx[1] = i_in_word.vert1_x; s_vy[1] = i_in_word.vert1_y;
        s_vx[2] = i_in_word.vert2_x; s_vy[2] = i_in_word.vert2_y;
        if (i_in_word.vert1_y <= i_in_word.vert0_y && i_in_word.vert1_y <= i_in_word.vert2_y)
        begin
            s_vx[0] = i_in_word.vert1_x; s_vy[0] = i_in_word.vert1_y;
            s_vx[1] = i_in_word.vert0_x; s_vy[1] = i_in_word.vert0_y;
        end else if (i_in_word.vert2_y <= i_in_word.vert0_y &&
                     i_in_word.vert2_y <= i_in_word.vert1_y) begin
            s_vx[0] = i_in_word.vert2_x; s_vy[0] = i_in_word.vert2_y;
            s_vx[2] = i_in_word.vert0_x; s_vy[2] = i_in_word.vert0_y;
        end
    end

    // shared walker unit
    t_walker              w_sel;
    t_walker              w_step;
    t_walker              w_init;
    logic                 at_end;
    logic signed [CB+2:0] e_sum;
    logic                 e_pos;
    logic signed [1:0]    dxs;
    logic signed [1:0]    dys;
    always_comb begin
        w_sel  = r_w[i_cmd.sel];
        at_end = (w_sel.px == w_sel.ex) && (w_sel.py == w_sel.ey);
        w_step = w_sel;
        w_step.ox = w_sel.px;
        w_step.oy = {w_sel.py[CB-1], w_sel.py};
        e_sum  = {w_sel.err[CB+1], w_sel.err} + $signed({2'b00, w_sel.dmin});
        e_pos  = e_sum > 0;
        dxs = w_sel.xmaj ? w_sel.maj : (e_pos ? w_sel.mnr : 2'sd0);
        dys = w_sel.xmaj ? (e_pos ? w_sel.mnr : 2'sd0) : w_sel.maj;
        if (!at_end) begin
            w_step.px  = w_sel.px + CB'(dxs);
            w_step.py  = w_sel.py + CB'(dys);
            w_step.err = e_pos ? (CB+2)'(e_sum - $signed({2'b00, w_sel.dmaj}))
                               : (CB+2)'(e_sum);
        end
        if (!i_cmd.seg) begin
            w_init = i_cmd.sel ? f_init(w_sel, r_vx[0], r_vy[0], r_vx[2], r_vy[2])
                               : f_init(w_sel, r_vx[0], r_vy[0], r_vx[1], r_vy[1]);
        end else begin
            w_init = i_cmd.sel ? f_init(w_sel, r_vx[2], r_vy[2], r_vx[1], r_vy[1])
                               : f_init(w_sel, r_vx[1], r_vy[1], r_vx[2], r_vy[2]);
        end
    end

    // span clipping
    logic signed [CB-1:0]          xa;
    logic signed [CB-1:0]          xb;
    logic signed [CB-1:0]          lft;
    logic signed [CB-1:0]          rgt;
    logic [tssg_pkg::CfgBits-1:0]  fw_c;
    logic [tssg_pkg::CfgBits-1:0]  fh_c;
    logic signed [CB+1:0]          lc;
    logic signed [CB+1:0]          rc;
    logic signed [CB+1:0]          wm1;
    logic                          vis;
    logic                          last;
    tssg_pkg::t_out_word           n_out;
    always_comb begin
        xa   = r_w[0].ox;
        xb   = r_w[1].ox;
        lft  = (xa < xb) ? xa : xb;
        rgt  = (xa < xb) ? xb : xa;
        fw_c = (r_fw > tssg_pkg::FrameMax) ? tssg_pkg::FrameMax : r_fw;
        fh_c = (r_fh > tssg_pkg::FrameMax) ? tssg_pkg::FrameMax : r_fh;
        wm1  = $signed((CB+2)'(fw_c)) - (CB+2)'(1);
        lc   = lft[CB-1] ? '0 : (CB+2)'(lft);
        rc   = ($signed((CB+2)'(rgt)) > wm1) ? wm1 : $signed((CB+2)'(rgt));
        vis  = !r_cur_row[CB-1] && ($signed((CB+2)'(r_cur_row)) < $signed((CB+2)'(fh_c)))
               && (lc <= rc);
        last = (r_cur_row == r_bottom);
        n_out.span_row     = r_cur_row;
        n_out.span_left    = vis ? lc[tssg_pkg::ColBits-1:0] : '0;
        n_out.span_right   = vis ? rc[tssg_pkg::ColBits-1:0] : '0;
        n_out.span_visible = vis;
        n_out.span_last    = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cur_row   <= '0;
            r_bottom    <= '0;
            r_guard     <= '0;
            r_fw        <= tssg_pkg::WidthRst;
            r_fh        <= tssg_pkg::HeightRst;
            r_out_valid <= 1'b0;
            r_w[0]      <= '0;
            r_w[1]      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    tssg_pkg::CfgWidth:  r_fw <= i_cfg_data;
                    tssg_pkg::CfgHeight: r_fh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin
                r_cur_row <= s_vy[0];
                r_bottom  <= (s_vy[1] > s_vy[2]) ? s_vy[1] : s_vy[2];
                r_active  <= 1'b1;
                r_w[0].ox <= '0;
                r_w[1].ox <= '0;
                r_w[0].oy <= {s_vy[0][CB-1], s_vy[0]} + (CB+1)'(1);
                r_w[1].oy <= {s_vy[0][CB-1], s_vy[0]} + (CB+1)'(1);
            end
            if (i_cmd.init) r_w[i_cmd.sel] <= w_init;
            if (i_cmd.step) begin
                r_w[i_cmd.sel] <= w_step;
                r_guard        <= r_guard - 1'b1;
            end
            if (i_cmd.guard_load) r_guard <= tssg_pkg::GuardInit;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (last) r_active  <= 1'b0;
                else      r_cur_row <= r_cur_row + CB'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            for (int i = 0; i < 3; i++) begin
                r_vx[i] <= s_vx[i];
                r_vy[i] <= s_vy[i];
            end
        end
        if (i_cmd.emit) r_out <= n_out;
    end

    assign o_stat.active     = r_active;
    assign o_stat.hit        = (w_sel.oy == {r_cur_row[CB-1], r_cur_row});
    assign o_stat.guard_zero = (r_guard == '0);
    assign o_stat.at_end     = at_end;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;

endmodule
`default_nettype wire

FILE: sv/tssg_ctrl.sv
// ---------------------------------------------------------------------------
// tssg_ctrl
// Controller: sequences load, walker initialisation, walker advance and emit.
// ---------------------------------------------------------------------------
`default_nettype none
module tssg_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_req_type,
    output logic            o_in_ready,
    input  tssg_pkg::t_stat i_stat,
    output tssg_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_INIT_A, S_INIT_B, S_ADV, S_REINIT, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == tssg_pkg::ReqLoad) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_INIT_A;
                    end else if (i_stat.active) begin
                        o_cmd.guard_load = 1'b1;
                        n_sel   = 1'b0;
                        n_state = S_ADV;
                    end
                end
            end
            S_INIT_A: begin
                o_cmd.init = 1'b1;
                o_cmd.sel  = 1'b0;
                n_state    = S_INIT_B;
            end
            S_INIT_B: begin
                o_cmd.init = 1'b1;
                o_cmd.sel  = 1'b1;
                n_state    = S_IDLE;
            end
            S_ADV: begin
                if (i_stat.hit || i_stat.guard_zero) begin
                    if (!r_sel) begin
                        o_cmd.guard_load = 1'b1;
                        n_sel = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_stat.at_end) n_state = S_REINIT;
                end
            end
            S_REINIT: begin
                o_cmd.init = 1'b1;
                o_cmd.seg  = 1'b1;
                n_state    = S_ADV;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

FILE: sv/triangle_scanline_span_gen_unit.sv
// ---------------------------------------------------------------------------
// triangle_scanline_span_gen_unit
// Triangle scan converter: Bresenham edge walk giving one clipped span a row.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) takes one word at a time. A load word
// latches three vertices, topmost first, and sets up edge walker A and then
// edge walker B; it gives no output. A step word gives one span word on the
// output channel (o_out_valid/i_out_ready) for the current row; a step with
// no triangle loaded is taken and dropped. A step word loads the step guard
// and steps walker A until it reaches the current row or the guard runs out,
// then walker B the same way; a walker that reaches the end of its first
// edge restarts on its second. The span is then emitted. Steep edges need
// one step per row, shallow edges one step per pixel walked. A new step word
// is taken once the span before it is emitted; the single shared walker step
// unit sets the step word rate. Configuration writes (frame width, height)
// take effect at once. Reset clears the triangle (no active triangle) and the
// output valid flag, and sets the frame to 640 x 480. A stalled receiver holds
// the span word in the output register; the next step word is still taken and
// worked on, and waits only when its own span is ready to leave.
// ---------------------------------------------------------------------------
`default_nettype none
module triangle_scanline_span_gen_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_addr,
    input  wire [tssg_pkg::CfgBits-1:0]  i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  tssg_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output tssg_pkg::t_out_word          o_out_word
);
    tssg_pkg::t_cmd  cmd;
    tssg_pkg::t_stat stat;

    tssg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_word.req_type),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tssg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

FILE: sv/tssg_checker.sv
// ---------------------------------------------------------------------------
// tssg_checker
// Port-level checks for the triangle span generator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "triangle_scanline_span_gen_unit_assert.svh"
module tssg_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input tssg_pkg::t_out_word o_out_word
);
    `TSSG_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "output word dropped or changed while stalled")
    `TSSG_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `TSSG_ASSERT(a_invis_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.span_visible |-> o_out_word.span_left == '0 && o_out_word.span_right == '0, "invisible span with nonzero columns")
    `TSSG_ASSERT(a_vis_order, i_clk, i_rst_n, o_out_valid && o_out_word.span_visible |-> o_out_word.span_left <= o_out_word.span_right, "visible span with left beyond right")
endmodule

bind triangle_scanline_span_gen_unit tssg_checker u_tssg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
`default_nettype wire
